// File: hw/rtl/nsvc_pkg.sv
// Shared types and constants of the managed object bring-up sequencer.
// Used by the front end, the event queue, the back end and the top level.
// No dependencies.
package nsvc_pkg;

  // Operational state of the managed object.
  typedef enum logic [1:0] {
    ST_NOTINST = 2'd0,
    ST_DEP     = 2'd1,
    ST_OFFLINE = 2'd2,
    ST_ENABLED = 2'd3
  } op_state_t;

  // Message requested toward the peer.
  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_ATTR   = 2'd1,
    REQ_UNLOCK = 2'd2,
    REQ_START  = 2'd3
  } req_t;

  // Event kind codes on the input word.
  localparam logic [2:0] KIND_FEAT       = 3'd0;
  localparam logic [2:0] KIND_SW_ACT     = 3'd1;
  localparam logic [2:0] KIND_REPORT     = 3'd2;
  localparam logic [2:0] KIND_ATTR_ACK   = 3'd3;
  localparam logic [2:0] KIND_START_ACK  = 3'd4;
  localparam logic [2:0] KIND_START_NACK = 3'd5;
  localparam logic [2:0] KIND_LINK_DOWN  = 3'd6;

  // Availability codes carried by a state report.
  localparam logic [2:0] AVAIL_NOTINST  = 3'd0;
  localparam logic [2:0] AVAIL_POWEROFF = 3'd1;
  localparam logic [2:0] AVAIL_DEP      = 3'd2;
  localparam logic [2:0] AVAIL_OFFLINE  = 3'd3;
  localparam logic [2:0] AVAIL_OK       = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GPRS      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_OFF  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IPV6_OK   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REMOTE_V6 = 2'd3;

  // Default depth of the event queue between front and back end.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Event class produced by the front end.
  typedef enum logic [3:0] {
    EV_FEAT,
    EV_SW_ACT,
    EV_REPORT_EN,
    EV_REPORT_DOWN,
    EV_REPORT_DEP,
    EV_REPORT_OFF,
    EV_REPORT_NOP,
    EV_ATTR_ACK,
    EV_START_DONE,
    EV_LINK_DOWN,
    EV_INVALID
  } ev_class_t;

  // Classified event as stored in the queue.
  typedef struct packed {
    ev_class_t ev;
    logic      admin;
    logic      features;
  } evt_t;

  // Configuration register file.
  typedef struct packed {
    logic gprs;
    logic skip_off;
    logic ipv6_ok;
    logic remote_v6;
  } cfg_t;

  // Progress flags of the bring-up sequence.
  typedef struct packed {
    logic attr_pend;
    logic attr_ack;
    logic unlock_req;
    logic start_req;
  } flags_t;

  // Queue status seen by the front end and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Result word; op_state sits in the lowest bits.
  typedef struct packed {
    logic      rejected;
    logic      address_error;
    req_t      send_request;
    op_state_t op_state;
  } res_t;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned RES_W      = $bits(res_t);

endpackage

// File: hw/rtl/nsvc_front.sv
// Front end of the bring-up sequencer: takes input words and classifies them.
// Depends on nsvc_pkg; feeds nsvc_queue.
module nsvc_front
  import nsvc_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  q_stat_t              q_stat,
  output logic                 push,
  output evt_t                 push_evt
);

  logic [2:0] kind;
  logic       op_en;
  logic [2:0] avail;

  assign kind  = in_tdata[2:0];
  assign op_en = in_tdata[3];
  assign avail = in_tdata[6:4];

  // Accept whenever the queue has room.
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  // Decode kind and availability into one event class.
  always_comb begin
    push_evt.admin    = in_tdata[7];
    push_evt.features = in_tdata[8];
    unique case (kind)
      KIND_FEAT:       push_evt.ev = EV_FEAT;
      KIND_SW_ACT:     push_evt.ev = EV_SW_ACT;
      KIND_ATTR_ACK:   push_evt.ev = EV_ATTR_ACK;
      KIND_START_ACK,
      KIND_START_NACK: push_evt.ev = EV_START_DONE;
      KIND_LINK_DOWN:  push_evt.ev = EV_LINK_DOWN;
      KIND_REPORT: begin
        if (op_en) begin
          push_evt.ev = EV_REPORT_EN;
        end else begin
          unique case (avail)
            AVAIL_NOTINST,
            AVAIL_POWEROFF: push_evt.ev = EV_REPORT_DOWN;
            AVAIL_DEP:      push_evt.ev = EV_REPORT_DEP;
            AVAIL_OFFLINE,
            AVAIL_OK:       push_evt.ev = EV_REPORT_OFF;
            default:        push_evt.ev = EV_REPORT_NOP;
          endcase
        end
      end
      default: push_evt.ev = EV_INVALID;
    endcase
  end

endmodule

// File: hw/rtl/nsvc_queue.sv
// Short event queue between the front and back ends of the sequencer.
// Depends on nsvc_pkg for the event and status types.
module nsvc_queue
  import nsvc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  evt_t    push_evt,
  input  logic    pop,
  output evt_t    pop_evt,
  output q_stat_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  evt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_evt      = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are read only after being written.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

endmodule

// File: hw/rtl/nsvc_back.sv
// Back end of the sequencer: state machine, progress flags and result register.
// Depends on nsvc_pkg; drains nsvc_queue.
module nsvc_back
  import nsvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  q_stat_t               q_stat,
  input  evt_t                  evt,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef struct packed {
    flags_t flags;
    req_t   req;
    logic   aerr;
  } adv_t;

  // One pass of the request logic over the flags.
  function automatic adv_t advance(cfg_t c, flags_t f, logic admin, logic feat,
                                   logic allow_start);
    adv_t r;
    r.flags = f;
    r.req   = REQ_NONE;
    r.aerr  = 1'b0;
    if (c.gprs) begin
      if (feat && !f.attr_pend && !f.attr_ack && c.remote_v6 && !c.ipv6_ok) begin
        r.aerr = 1'b1;
      end else begin
        if (feat && !f.attr_pend && !f.attr_ack) begin
          r.flags.attr_pend = 1'b1;
          r.req             = REQ_ATTR;
        end
        if (r.flags.attr_ack && !admin && !r.flags.unlock_req) begin
          r.flags.unlock_req = 1'b1;
          r.req              = REQ_UNLOCK;
        end
        if (allow_start && admin && r.flags.attr_ack && !r.flags.start_req) begin
          r.flags.start_req = 1'b1;
          r.req             = REQ_START;
        end
      end
    end
    return r;
  endfunction

  op_state_t state_r, state_nxt;
  flags_t    flags_r, flags_nxt;
  res_t      res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic      accepted;
  logic      do_enter;
  op_state_t enter_raw;
  op_state_t enter_st;
  logic      do_adv;
  logic      adv_allow;
  flags_t    flags_pre;
  adv_t      adv;

  // Take an event when the result register is free or being emptied.
  assign pop        = !q_stat.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), res_r};

  // Events that each state accepts.
  always_comb begin
    unique case (state_r)
      ST_NOTINST: accepted = (evt.ev != EV_ATTR_ACK) && (evt.ev != EV_INVALID);
      ST_DEP,
      ST_OFFLINE: accepted = (evt.ev != EV_SW_ACT) && (evt.ev != EV_INVALID);
      default:    accepted = (evt.ev != EV_FEAT) && (evt.ev != EV_SW_ACT) &&
                             (evt.ev != EV_ATTR_ACK) && (evt.ev != EV_INVALID);
    endcase
  end

  // Decide on a state entry or an in-place advance for the event.
  always_comb begin
    do_enter  = 1'b0;
    enter_raw = state_r;
    do_adv    = 1'b0;
    adv_allow = 1'b0;
    flags_pre = flags_r;
    unique case (evt.ev)
      EV_START_DONE: flags_pre.start_req = 1'b0;
      EV_LINK_DOWN,
      EV_REPORT_DOWN: begin
        do_enter  = (state_r != ST_NOTINST);
        enter_raw = ST_NOTINST;
      end
      EV_FEAT: begin
        do_adv    = (state_r == ST_DEP) || (state_r == ST_OFFLINE);
        adv_allow = (state_r == ST_OFFLINE);
      end
      EV_ATTR_ACK: begin
        flags_pre.attr_ack  = 1'b1;
        flags_pre.attr_pend = 1'b0;
        do_adv              = 1'b1;
        adv_allow           = (state_r == ST_OFFLINE);
      end
      EV_REPORT_EN: begin
        do_enter  = (state_r != ST_ENABLED);
        enter_raw = ST_ENABLED;
      end
      EV_REPORT_DEP: begin
        if (state_r == ST_DEP) begin
          do_adv = 1'b1;
        end else if (state_r == ST_OFFLINE && cfg.skip_off) begin
          do_adv    = 1'b1;
          adv_allow = 1'b1;
        end else begin
          do_enter  = 1'b1;
          enter_raw = ST_DEP;
        end
      end
      EV_REPORT_OFF: begin
        if (state_r == ST_OFFLINE) begin
          do_adv    = 1'b1;
          adv_allow = 1'b1;
        end else begin
          do_enter  = 1'b1;
          enter_raw = ST_OFFLINE;
        end
      end
      default: ;
    endcase

    // The peer quirk turns a dependency entry into an offline entry.
    enter_st = (enter_raw == ST_DEP && cfg.skip_off) ? ST_OFFLINE : enter_raw;
    if (do_enter) begin
      do_adv    = (enter_st == ST_DEP) || (enter_st == ST_OFFLINE);
      adv_allow = (enter_st == ST_OFFLINE);
    end
  end

  assign adv = advance(cfg, flags_pre, evt.admin, evt.features, adv_allow);

  // Next state, flags and result.
  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    res_nxt       = res_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (pop) begin
      out_valid_nxt         = 1'b1;
      res_nxt.op_state      = state_r;
      res_nxt.send_request  = REQ_NONE;
      res_nxt.address_error = 1'b0;
      res_nxt.rejected      = !accepted;
      if (accepted) begin
        flags_nxt = flags_pre;
        if (do_enter) begin
          state_nxt = enter_st;
          if (!do_adv) begin
            flags_nxt = '0;
          end
        end
        if (do_adv) begin
          flags_nxt             = adv.flags;
          res_nxt.send_request  = adv.req;
          res_nxt.address_error = adv.aerr;
        end
        res_nxt.op_state = state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_NOTINST;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: hw/rtl/nsvc_managed_object_bringup_fsm_core.sv
// Top level of the managed object bring-up sequencer.
// Depends on nsvc_pkg, nsvc_front, nsvc_queue and nsvc_back.
//
// Usage:
//   Events enter on the in_ stream, one word per event. Each event gives
//   exactly one result word on the out_ stream, in order. Four one-bit
//   configuration registers are written through cfg_wr_en, cfg_addr and
//   cfg_wr_data, and are meant to change only while no event is in flight.
//   An accepted event passes the event queue and then the back end result
//   register before its result is valid. Throughput: one event per cycle
//   while out_tready is high; the back end updates state and flags as it
//   takes each event, so consecutive events follow each other directly.
//   The front end writes into a queue of QUEUE_DEPTH entries; the back end
//   drains it into a result register. When the receiver holds out_tready
//   low, the result register holds, the queue fills, and in_tready drops
//   once the queue is full.
//   Reset (synchronous, active low) returns the object to not installed,
//   clears all progress flags and configuration registers, and empties the
//   queue and the result register.
module nsvc_managed_object_bringup_fsm_core
  import nsvc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: kind[2:0], operational_enabled[3], availability[6:4],
  // admin_unlocked[7], features_ready[8], zero[15:9]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: op_state[1:0], send_request[3:2], address_error[4],
  // rejected[5], zero[7:6]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic                  cfg_wr_data
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  logic    push;
  evt_t    push_evt;
  logic    pop;
  evt_t    pop_evt;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_GPRS:      cfg_nxt.gprs      = cfg_wr_data;
        CFG_SKIP_OFF:  cfg_nxt.skip_off  = cfg_wr_data;
        CFG_IPV6_OK:   cfg_nxt.ipv6_ok   = cfg_wr_data;
        CFG_REMOTE_V6: cfg_nxt.remote_v6 = cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nsvc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_evt  (push_evt)
  );

  nsvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .pop_evt  (pop_evt),
    .q_stat   (q_stat)
  );

  nsvc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .evt        (pop_evt),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // An event entering an idle block shows its result after the queue and the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_stat.empty && !out_tvalid) |-> ##2 out_tvalid)
    else $error("result missing after event entered an idle block");

  // Entering enabled clears all flags, so no message goes out there.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == ST_ENABLED) |->
      (out_tdata[3:2] == REQ_NONE && !out_tdata[4]))
    else $error("message requested in enabled state");

  // The back end never pops from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty event queue");

  // Input is refused only while the queue is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full)
    else $error("input stalled with room in the queue");

endmodule
